>>> hdl/beacon_frame_parser_crc16_core_assert.svh
// Assertion macros shared by the checker of the beacon frame parser.
// No dependencies; included by the checker file only.
`ifndef BEACON_FRAME_PARSER_CRC16_CORE_ASSERT_SVH
`define BEACON_FRAME_PARSER_CRC16_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BFP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfp check failed");

// Consequent holds in the cycle after the antecedent, reset included.
`define BFP_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bfp check failed");

`endif

>>> hdl/bfp_pkg.sv
// Package for the beacon frame parser: constants, shared types and the CRC step.
// No dependencies.
package bfp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int NUM_BEACONS = 4;
    localparam int FRAME_DEPTH = MAX_PAYLOAD + 5;
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
    localparam int SLOT_W      = 4;
    localparam int NUM_SLOTS   = 1 << SLOT_W;
    localparam int BID_W       = $clog2(NUM_BEACONS);
    localparam int CFG_IDX_W   = 2;
    localparam int MEM_AW      = SLOT_W + 1;
    localparam int MEM_DEPTH   = 1 << MEM_AW;

    // Header and marker bytes.
    localparam logic [7:0] SOF_BYTE  = 8'h01;
    localparam logic [7:0] FUNC_BYTE = 8'h03;
    localparam logic [7:0] MARK_0    = 8'hAC;
    localparam logic [7:0] MARK_1    = 8'hDA;
    localparam logic [7:0] MARK_2    = 8'h00;
    localparam logic [7:0] MARK_3    = 8'h03;

    // Frame offsets of the position words and of the first distance slot.
    localparam int POS_OFS   = 39;
    localparam int DIST_OFS  = 7;
    localparam int MIN_TOTAL = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Reset values of the beacon slot registers.
    localparam logic [SLOT_W-1:0] ID_RST [NUM_BEACONS] = '{4'd0, 4'd5, 4'd3, 4'd2};

    // One finished frame handed from the front to the back.
    typedef struct packed {
        logic               bank;
        logic [CNT_W-1:0]   total;
        logic signed [15:0] pos_east;
        logic signed [15:0] pos_north;
        logic signed [15:0] pos_up;
    } t_entry;

    // Write of one distance slot byte into the slot memory.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [SLOT_W-1:0] slot;
        logic              hi;
        logic [7:0]        data;
    } t_mem_wr;

    // One byte of the reflected Modbus CRC-16.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/bfp_front.sv
// Front part of the beacon frame parser: header hunt, byte capture and CRC check.
// Depends on bfp_pkg.
module bfp_front
    import bfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rx_valid,
    input  logic [7:0] i_rx_byte,
    output logic    o_rx_ready,
    input  logic    i_q_full,
    output logic    o_push,
    output t_entry  o_entry,
    output t_mem_wr o_mem_wr
);

    typedef enum logic [2:0] {
        PH_SOF, PH_FUNC, PH_LEN, PH_M0, PH_M1, PH_M2, PH_M3, PH_BODY
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_count;
    logic [7:0]         r_len;
    logic [7:0]         r_prev;
    logic [15:0]        r_crc;
    logic               r_bank;
    logic [7:0]         r_posb [6];

    logic               w_accept, w_store, w_feed, w_last, w_crc_ok, w_dist;
    logic [CNT_W-1:0]   w_n, w_total, w_dofs;
    logic [7:0]         w_len;
    logic [15:0]        w_crc_in;
    logic [7:0]         w_pb [6];

    // A word is taken whenever the queue has room for a finished frame.
    assign o_rx_ready = !i_q_full;
    assign w_accept   = i_rx_valid && !i_q_full;

    // Header recognition.
    always_comb begin
        n_phase = r_phase;
        w_store = 1'b0;
        case (r_phase)
            PH_SOF: begin
                if (i_rx_byte == SOF_BYTE) begin
                    w_store = 1'b1;
                    n_phase = PH_FUNC;
                end
            end
            PH_FUNC: begin
                w_store = (i_rx_byte == FUNC_BYTE);
                n_phase = w_store ? PH_LEN : PH_SOF;
            end
            PH_LEN: begin
                w_store = 1'b1;
                n_phase = (i_rx_byte > 8'(MAX_PAYLOAD)) ? PH_SOF : PH_M0;
            end
            PH_M0: begin
                w_store = (i_rx_byte == MARK_0);
                n_phase = w_store ? PH_M1 : PH_SOF;
            end
            PH_M1: begin
                w_store = (i_rx_byte == MARK_1);
                n_phase = w_store ? PH_M2 : PH_SOF;
            end
            PH_M2: begin
                w_store = (i_rx_byte == MARK_2);
                n_phase = w_store ? PH_M3 : PH_SOF;
            end
            PH_M3: begin
                w_store = (i_rx_byte == MARK_3);
                n_phase = w_store ? PH_BODY : PH_SOF;
            end
            PH_BODY: begin
                w_store = 1'b1;
                n_phase = w_last ? PH_SOF : PH_BODY;
            end
            default: begin
                n_phase = PH_SOF;
            end
        endcase
    end

    // Frame position, frame length and CRC feeding rule.
    always_comb begin
        w_n      = (r_phase == PH_SOF) ? '0 : r_count;
        w_len    = (r_phase == PH_LEN) ? i_rx_byte : r_len;
        w_total  = (w_len < 8'd3) ? CNT_W'(MIN_TOTAL) : CNT_W'(w_len) + CNT_W'(5);
        w_crc_in = (r_phase == PH_SOF) ? CRC_INIT : r_crc;
        w_feed   = (w_n < CNT_W'(3)) ||
                   ({1'b0, w_n} + (CNT_W+1)'(2) < {1'b0, w_total});
        w_last   = (r_phase == PH_BODY) && ({1'b0, w_n} + (CNT_W+1)'(1) == {1'b0, w_total});
        w_crc_ok = (r_crc[7:0] == r_prev) && (r_crc[15:8] == i_rx_byte);
    end

    // Position bytes as read at the end of the frame; the last byte bypasses.
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            if (CNT_W'(POS_OFS + k) < w_total) begin
                w_pb[k] = (w_n == CNT_W'(POS_OFS + k)) ? i_rx_byte : r_posb[k];
            end else begin
                w_pb[k] = 8'h00;
            end
        end
    end

    assign o_push            = w_accept && w_last && w_crc_ok;
    assign o_entry.bank      = r_bank;
    assign o_entry.total     = w_total;
    assign o_entry.pos_east  = {w_pb[0], w_pb[1]};
    assign o_entry.pos_north = {w_pb[2], w_pb[3]};
    assign o_entry.pos_up    = {w_pb[4], w_pb[5]};

    // Distance slot bytes go to the back part's slot memory.
    assign w_dofs        = w_n - CNT_W'(DIST_OFS);
    assign w_dist        = (w_n >= CNT_W'(DIST_OFS)) &&
                           (w_n < CNT_W'(DIST_OFS + 2 * NUM_SLOTS));
    assign o_mem_wr.en   = w_accept && w_store && w_dist;
    assign o_mem_wr.bank = r_bank;
    assign o_mem_wr.slot = w_dofs[SLOT_W:1];
    assign o_mem_wr.hi   = w_n[0];
    assign o_mem_wr.data = i_rx_byte;

    // Parser state and captured bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SOF;
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_bank  <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            if (w_store) begin
                r_count <= w_n + CNT_W'(1);
                r_prev  <= i_rx_byte;
                r_crc   <= w_feed ? crc16_byte(w_crc_in, i_rx_byte) : w_crc_in;
                for (int k = 0; k < 6; k++) begin
                    if (w_n == CNT_W'(POS_OFS + k)) begin
                        r_posb[k] <= i_rx_byte;
                    end
                end
            end
            if (r_phase == PH_LEN) begin
                r_len <= i_rx_byte;
            end
            if (o_push) begin
                r_bank <= !r_bank;
            end
        end
    end

endmodule

>>> hdl/bfp_queue.sv
// Two-entry queue of finished frames between the front and the back part.
// Depends on bfp_pkg.
module bfp_queue
    import bfp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_valid,
    output logic   o_full,
    output t_entry o_entry
);

    t_entry     r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_entry = r_ent[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_ent[r_wp] <= i_entry;
                r_wp        <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> hdl/bfp_back.sv
// Back part of the beacon frame parser: slot memory, distance lookup and result register.
// Depends on bfp_pkg.
module bfp_back
    import bfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SLOT_W-1:0]    i_cfg_data,
    input  t_mem_wr              i_mem_wr,
    input  logic                 i_q_valid,
    input  t_entry               i_q_entry,
    output logic                 o_q_pop,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic signed [15:0]   o_pos_east,
    output logic signed [15:0]   o_pos_north,
    output logic signed [15:0]   o_pos_up,
    output logic [15:0]          o_dist_a,
    output logic [15:0]          o_dist_b,
    output logic [15:0]          o_dist_c,
    output logic [15:0]          o_dist_d
);

    localparam int ISS_W = $clog2(NUM_BEACONS + 1);

    logic [7:0]          r_mem_hi [MEM_DEPTH];
    logic [7:0]          r_mem_lo [MEM_DEPTH];
    logic [7:0]          r_rd_hi, r_rd_lo;
    logic [SLOT_W-1:0]   r_id [NUM_BEACONS];
    logic [ISS_W-1:0]    r_issue;
    logic                r_rd_v, r_mhi, r_mlo;
    logic [BID_W-1:0]    r_rd_idx;
    logic [15:0]         r_dist [NUM_BEACONS];
    logic                r_res_valid;
    logic signed [15:0]  r_pos_east, r_pos_north, r_pos_up;
    logic [15:0]         r_out_dist [NUM_BEACONS];

    logic                w_issue, w_done, w_load;
    logic [SLOT_W-1:0]   w_rid;
    logic [MEM_AW-1:0]   w_raddr, w_waddr;
    logic [CNT_W-1:0]    w_hi_ofs;

    // Read address for the next beacon of the frame at the queue head.
    assign w_rid    = r_id[r_issue[BID_W-1:0]];
    assign w_raddr  = {i_q_entry.bank, w_rid};
    assign w_waddr  = {i_mem_wr.bank, i_mem_wr.slot};
    assign w_hi_ofs = CNT_W'(DIST_OFS) + CNT_W'({w_rid, 1'b0});

    assign w_issue = i_q_valid && (r_issue != ISS_W'(NUM_BEACONS));
    assign w_done  = i_q_valid && (r_issue == ISS_W'(NUM_BEACONS)) && !r_rd_v;
    assign w_load  = w_done && (!r_res_valid || i_res_ready);
    assign o_q_pop = w_load;

    // Slot memory, one bank per frame in flight, registered read.
    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en && i_mem_wr.hi) begin
            r_mem_hi[w_waddr] <= i_mem_wr.data;
        end
        if (i_mem_wr.en && !i_mem_wr.hi) begin
            r_mem_lo[w_waddr] <= i_mem_wr.data;
        end
        r_rd_hi <= r_mem_hi[w_raddr];
        r_rd_lo <= r_mem_lo[w_raddr];
    end

    // Beacon slot registers, lookup sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id        <= ID_RST;
            r_issue     <= '0;
            r_rd_v      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_id[i_cfg_idx] <= i_cfg_data;
            end
            r_rd_v <= w_issue;
            if (w_issue) begin
                r_rd_idx <= r_issue[BID_W-1:0];
                r_mhi    <= (w_hi_ofs < i_q_entry.total);
                r_mlo    <= (w_hi_ofs + CNT_W'(1) < i_q_entry.total);
                r_issue  <= r_issue + ISS_W'(1);
            end else if (w_load) begin
                r_issue <= '0;
            end
            // Bytes beyond the end of the frame read as zero.
            if (r_rd_v) begin
                r_dist[r_rd_idx] <= {r_mhi ? r_rd_hi : 8'h00, r_mlo ? r_rd_lo : 8'h00};
            end
            if (w_load) begin
                r_res_valid <= 1'b1;
                r_pos_east  <= i_q_entry.pos_east;
                r_pos_north <= i_q_entry.pos_north;
                r_pos_up    <= i_q_entry.pos_up;
                r_out_dist  <= r_dist;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_pos_east  = r_pos_east;
    assign o_pos_north = r_pos_north;
    assign o_pos_up    = r_pos_up;
    assign o_dist_a    = r_out_dist[0];
    assign o_dist_b    = r_out_dist[1];
    assign o_dist_c    = r_out_dist[2];
    assign o_dist_d    = r_out_dist[3];

endmodule

>>> hdl/beacon_frame_parser_crc16_core.sv
// Top level of the beacon frame parser with CRC-16 check.
// Depends on bfp_pkg, bfp_front, bfp_queue and bfp_back.
//
//   channel   direction  handshake                   word
//   rx        in         i_rx_valid / o_rx_ready     i_rx_byte
//   res       out        o_res_valid / i_res_ready   o_pos_*, o_dist_a..d
//   cfg       in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One received byte is taken every cycle while o_rx_ready is high; the CRC and
// header check run per byte. A frame with a good CRC goes through the frame queue
// and four reads of the distance slot memory, one per beacon, to the output.
// Up to two good frames may wait; with both pending, o_rx_ready drops.
// Reset is synchronous and active low; no clearing pass is needed after it.
module beacon_frame_parser_crc16_core
    import bfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic signed [15:0]   o_pos_east,
    output logic signed [15:0]   o_pos_north,
    output logic signed [15:0]   o_pos_up,
    output logic [15:0]          o_dist_a,
    output logic [15:0]          o_dist_b,
    output logic [15:0]          o_dist_c,
    output logic [15:0]          o_dist_d,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SLOT_W-1:0]    i_cfg_data
);

    logic    w_push, w_pop, w_q_valid, w_q_full;
    t_entry  w_push_entry, w_head_entry;
    t_mem_wr w_mem_wr;

    // Byte hunt and frame check.
    bfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_ready (o_rx_ready),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_entry    (w_push_entry),
        .o_mem_wr   (w_mem_wr)
    );

    // Finished frames waiting for the back part.
    bfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_entry (w_head_entry)
    );

    // Distance lookup and result register.
    bfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_mem_wr    (w_mem_wr),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_head_entry),
        .o_q_pop     (w_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_pos_east  (o_pos_east),
        .o_pos_north (o_pos_north),
        .o_pos_up    (o_pos_up),
        .o_dist_a    (o_dist_a),
        .o_dist_b    (o_dist_b),
        .o_dist_c    (o_dist_c),
        .o_dist_d    (o_dist_d)
    );

endmodule

>>> hdl/bfp_checker.sv
// Port-level checks of the beacon frame parser, bound to the top level.
// Depends on beacon_frame_parser_crc16_core_assert.svh.
`include "beacon_frame_parser_crc16_core_assert.svh"

module bfp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_rx_ready,
    input logic                 o_res_valid,
    input logic                 i_res_ready,
    input logic signed [15:0]   o_pos_east,
    input logic signed [15:0]   o_pos_north,
    input logic signed [15:0]   o_pos_up,
    input logic [15:0]          o_dist_a,
    input logic [15:0]          o_dist_b,
    input logic [15:0]          o_dist_c,
    input logic [15:0]          o_dist_d
);

    logic         w_hold;
    logic [111:0] w_res_word;

    // A result is held when it is offered and not taken.
    assign w_hold     = o_res_valid && !i_res_ready;
    assign w_res_word = {o_pos_east, o_pos_north, o_pos_up,
                         o_dist_a, o_dist_b, o_dist_c, o_dist_d};

    // A result waiting at the output stays, and its word holds.
    `BFP_ASSERT_NEXT(a_res_held, i_clk, i_rst_n && w_hold, o_res_valid)
    `BFP_ASSERT_SAME(a_res_stable, i_clk, i_rst_n, $past(w_hold), $stable(w_res_word))

    // Reset empties the result register and the frame queue.
    `BFP_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_res_valid)
    `BFP_ASSERT_NEXT(a_rst_ready, i_clk, !i_rst_n, o_rx_ready)

endmodule

bind beacon_frame_parser_crc16_core bfp_checker u_bfp_checker (.*);
